/* src/gshare_branch_predictor_assert.svh */
// assertion macros shared by the gshare predictor checker
// each macro expects clk and rst to be visible where it is used
`ifndef GSHARE_BRANCH_PREDICTOR_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define GSBP_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gsbp assertion failed");

// next-cycle implication, masked while reset is high
`define GSBP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gsbp assertion failed");

// next-cycle implication that also covers the reset cycles
`define GSBP_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("gsbp assertion failed");

`endif

/* src/gsbp_pkg.sv */
// shared types, constants and helpers of the gshare branch predictor
// no dependencies
`default_nettype none

package gsbp_pkg;

  localparam int INDEX_BITS_DEFAULT = 12;
  localparam int PC_BITS            = 64;
  localparam int CTR_BITS           = 2;
  localparam int COUNT_BITS         = 32;

  // stream payload layout
  localparam int IN_DATA_BITS  = 72;   // pc, predicted_taken_in, resolved_taken, pad
  localparam int OUT_DATA_BITS = 72;   // predict_taken, branches_seen, mispredictions, pad

  localparam logic [CTR_BITS-1:0]   CTR_RESET = 2'd2;
  localparam logic [CTR_BITS-1:0]   CTR_MAX   = 2'd3;
  localparam logic [CTR_BITS-1:0]   CTR_MIN   = 2'd0;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic MODE_ALWAYS_TAKEN = 1'b0;
  localparam logic MODE_GSHARE       = 1'b1;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  // two-bit saturating counter step toward the outcome
  function automatic logic [CTR_BITS-1:0] ctr_step(input logic [CTR_BITS-1:0] c,
                                                   input logic up);
    logic [CTR_BITS-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 1'b1;
    end else begin
      if (c != CTR_MIN) r = c - 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/gsbp_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module gsbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/gsbp_init.sv */
// sweep that writes the reset counter value into every table entry after reset
// depends on nothing but its parameter
`default_nettype none

module gsbp_init #(
  parameter int INDEX_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  output logic                       busy,
  output logic      [INDEX_BITS-1:0] addr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      addr <= addr + 1'b1;
      if (addr == {INDEX_BITS{1'b1}}) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/gsbp_stats.sv */
// saturating totals of resolved branches and mispredictions
// depends on gsbp_pkg
`default_nettype none

module gsbp_stats (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            upd,
  input  wire logic                            miss,
  output logic      [gsbp_pkg::COUNT_BITS-1:0] branches_next,
  output logic      [gsbp_pkg::COUNT_BITS-1:0] misp_next
);
  import gsbp_pkg::*;

  logic [COUNT_BITS-1:0] branches;
  logic [COUNT_BITS-1:0] misp;

  // totals as they stand after this cycle's transfer
  always_comb begin
    branches_next = branches;
    misp_next     = misp;
    if (upd) begin
      if (branches != COUNT_MAX) branches_next = branches + 1'b1;
      if (miss && misp != COUNT_MAX) misp_next = misp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      branches <= '0;
      misp     <= '0;
    end else begin
      branches <= branches_next;
      misp     <= misp_next;
    end
  end

endmodule

`default_nettype wire

/* src/gshare_branch_predictor.sv */
// gshare predictor: an accepted item reads the counter table into the s1 stage,
// and its result is loaded into the output register when s1 advances.
// throughput is one item per cycle while the output is not stalled; the table has
// one write and one read port and a one-entry forward covers an update followed
// directly by a read. after reset s_tready stays low while the table is swept to
// weakly taken; configuration writes are taken throughout.
`default_nettype none

module gshare_branch_predictor #(
  parameter int INDEX_BITS = gsbp_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // config: predict_mode
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_data,
  // s_tdata: pc[63:0], predicted_taken_in[64], resolved_taken[65], zero pad
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [gsbp_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // s_tuser: op[0]
  input  wire logic                               s_tuser,
  // m_tdata: predict_taken[0], branches_seen[32:1], mispredictions[64:33], zero pad
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [gsbp_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import gsbp_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;

  logic                  predict_mode;
  logic [INDEX_BITS-1:0] history;
  logic [INDEX_BITS-1:0] last_index;

  logic                  in_xfer;
  op_t                   in_op;
  logic                  in_pred;
  logic                  in_taken;
  logic [INDEX_BITS-1:0] rd_idx;

  logic                  init_busy;
  logic [INDEX_BITS-1:0] init_addr;

  logic [COUNT_BITS-1:0] branches_next;
  logic [COUNT_BITS-1:0] misp_next;

  // table read stage
  logic                  s1_valid;
  op_t                   s1_op;
  logic                  s1_table;
  logic                  s1_taken;
  logic [INDEX_BITS-1:0] s1_idx;
  logic [COUNT_BITS-1:0] s1_branches;
  logic [COUNT_BITS-1:0] s1_misp;
  logic                  s1_adv;
  logic                  s1_answer;

  logic [CTR_BITS-1:0]   ram_q;
  logic [CTR_BITS-1:0]   ctr_cur;
  logic                  we;
  logic [INDEX_BITS-1:0] waddr;
  logic [CTR_BITS-1:0]   wdata;

  logic                  fwd_valid;
  logic [INDEX_BITS-1:0] fwd_idx;
  logic [CTR_BITS-1:0]   fwd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      predict_mode <= MODE_GSHARE;
    end else if (cfg_valid && cfg_ready) begin
      predict_mode <= cfg_data;
    end
  end

  assign in_op    = op_t'(s_tuser);
  assign in_pred  = s_tdata[PC_BITS];
  assign in_taken = s_tdata[PC_BITS+1];
  assign rd_idx   = (in_op == OP_PREDICT) ? (s_tdata[INDEX_BITS-1:0] ^ history) : last_index;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !init_busy && (!s1_valid || s1_adv);
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      last_index <= '0;
    end else if (in_xfer) begin
      if (in_op == OP_UPDATE) begin
        history <= {history[INDEX_BITS-2:0], in_taken};
      end else if (predict_mode == MODE_GSHARE) begin
        last_index <= rd_idx;
      end
    end
  end

  gsbp_init #(
    .INDEX_BITS(INDEX_BITS)
  ) u_init (
    .clk (clk),
    .rst (rst),
    .busy(init_busy),
    .addr(init_addr)
  );

  gsbp_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .upd          (in_xfer && in_op == OP_UPDATE),
    .miss         (in_pred != in_taken),
    .branches_next(branches_next),
    .misp_next    (misp_next)
  );

  gsbp_ram #(
    .WIDTH(CTR_BITS),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (in_xfer),
    .raddr(rd_idx),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op       <= in_op;
      s1_table    <= (predict_mode == MODE_GSHARE);
      s1_taken    <= in_taken;
      s1_idx      <= rd_idx;
      s1_branches <= branches_next;
      s1_misp     <= misp_next;
    end
  end

  // a write in the cycle of the read is not yet in the ram data
  assign ctr_cur = (fwd_valid && fwd_idx == s1_idx) ? fwd_data : ram_q;

  always_comb begin
    if (init_busy) begin
      we    = 1'b1;
      waddr = init_addr;
      wdata = CTR_RESET;
    end else begin
      we    = s1_adv && s1_op == OP_UPDATE;
      waddr = s1_idx;
      wdata = ctr_step(ctr_cur, s1_taken);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we && !init_busy) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !init_busy) begin
      fwd_idx  <= waddr;
      fwd_data <= wdata;
    end
  end

  // weakly or strongly taken counters have the high bit set
  assign s1_answer = (s1_op == OP_PREDICT) && (!s1_table || ctr_cur[CTR_BITS-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {{(OUT_DATA_BITS - 1 - 2*COUNT_BITS){1'b0}}, s1_misp, s1_branches, s1_answer};
    end
  end

endmodule

`default_nettype wire

/* src/gsbp_checker.sv */
// port-level checks on the gshare predictor, bound to the top level
// depends on gsbp_pkg and gshare_branch_predictor_assert.svh
`default_nettype none

`include "gshare_branch_predictor_assert.svh"

module gsbp_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [gsbp_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import gsbp_pkg::*;

  // a stalled result holds
  `GSBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // mispredictions are a subset of the counted branches
  `GSBP_ASSERT(a_misp_le_branches, m_tvalid,
               m_tdata[2*COUNT_BITS:COUNT_BITS+1] <= m_tdata[COUNT_BITS:1])

  // reset empties the output and starts the table sweep
  `GSBP_ASSERT_RST(a_reset_quiet, rst, !m_tvalid && !s_tready)

  // the branch total never steps back across back-to-back results
  `GSBP_ASSERT_NEXT(a_count_mono, m_tvalid && m_tready,
                    !m_tvalid || m_tdata[COUNT_BITS:1] >= $past(m_tdata[COUNT_BITS:1]))

endmodule

bind gshare_branch_predictor gsbp_checker u_gsbp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
